/* rtl/core/psp_pkg.sv */
// Shared types, constants and register offsets for the sixteen-channel sample player.
package psp_pkg;

  // Build constants
  localparam int CHANNELS      = 16;
  localparam int ROM_ADDR_BITS = 19;
  localparam int ROM_DEPTH     = 1 << ROM_ADDR_BITS;
  localparam int CH_BITS       = 4;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 10;
  localparam int MUL_B_W = 18;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

  // Host function codes carried on in_tuser
  typedef enum logic [1:0] {
    FUNC_WR_REG = 2'd0,
    FUNC_RD_REG = 2'd1,
    FUNC_LOAD   = 2'd2,
    FUNC_RENDER = 2'd3
  } func_t;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_BANK_SHIFT  = 2'd0,
    REG_BANK_MASK   = 2'd1,
    REG_REGION_MASK = 2'd2,
    REG_STEP_SCALE  = 2'd3
  } reg_idx_t;

  // Per-channel offsets inside the register store
  localparam logic [7:0] OFS_LVOL   = 8'h02;
  localparam logic [7:0] OFS_RVOL   = 8'h03;
  localparam logic [7:0] OFS_LOOP_M = 8'h04;
  localparam logic [7:0] OFS_LOOP_H = 8'h05;
  localparam logic [7:0] OFS_END    = 8'h06;
  localparam logic [7:0] OFS_PITCH  = 8'h07;
  localparam logic [7:0] OFS_CUR_M  = 8'h84;
  localparam logic [7:0] OFS_CUR_H  = 8'h85;
  localparam logic [7:0] OFS_FLAGS  = 8'h86;

  localparam logic [7:0] SAMPLE_BIAS = 8'h80;
  localparam logic [7:0] STORE_RESET = 8'hff;

  // Configuration as seen by the render engine
  typedef struct packed {
    logic [4:0]  bank_shift;
    logic [7:0]  bank_mask;
    logic [15:0] region_mask;
    logic [17:0] step_scale;
  } cfg_t;

  // Register store access: one write and one read port
  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } store_req_t;

  // Sample memory access: single address, write or read
  typedef struct packed {
    logic                     we;
    logic [ROM_ADDR_BITS-1:0] addr;
    logic [7:0]               wdata;
  } rom_req_t;

endpackage

/* rtl/core/pcm_sample_player_16ch.sv */
// Sixteen-channel sample player top level: configuration registers and block wiring.
//
// Each accepted beat carries one host command; exactly one result beat follows.
// A render frame walks the channels in turn with one register-store port: an
// inactive channel needs only the snapshot reads and the decision; a playing one
// adds the sample fetch, three passes through the shared multiplier for left
// volume, right volume and pitch step, and three write-backs; a voice that
// stops at its end is written back without fetch or multiply. The input is not
// ready while a command is in progress; a finished result sits in the output
// register, and the next command is taken while it waits. Configuration writes
// belong to idle periods.
module pcm_sample_player_16ch
  import psp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,    // func
  input  logic [47:0] in_tdata,    // reg_addr[7:0], reg_data[15:8], rom_addr[34:16],
                                   // rom_data[42:35], zero fill
  // Result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,   // read_data[7:0], left_out[27:8], right_out[47:28]
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [4:0]  bank_shift_r;
  logic [7:0]  bank_mask_r;
  logic [15:0] region_mask_r;
  logic [17:0] step_scale_r;
  logic        cfg_wr;
  reg_idx_t    cfg_idx;
  cfg_t        cfg;

  store_req_t                st_req;
  logic [7:0]                st_rdata;
  rom_req_t                  rom_req;
  logic [7:0]                rom_rdata;
  logic signed [MUL_A_W-1:0] mul_a;
  logic        [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_shift_r  <= 5'd12;
      bank_mask_r   <= 8'd112;
      region_mask_r <= 16'hffff;
      step_scale_r  <= 18'd47554;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BANK_SHIFT:  bank_shift_r  <= cfg_pwdata[4:0];
        REG_BANK_MASK:   bank_mask_r   <= cfg_pwdata[7:0];
        REG_REGION_MASK: region_mask_r <= cfg_pwdata[15:0];
        REG_STEP_SCALE:  step_scale_r  <= cfg_pwdata[17:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    case (cfg_idx)
      REG_BANK_SHIFT:  cfg_prdata = 32'(bank_shift_r);
      REG_BANK_MASK:   cfg_prdata = 32'(bank_mask_r);
      REG_REGION_MASK: cfg_prdata = 32'(region_mask_r);
      REG_STEP_SCALE:  cfg_prdata = 32'(step_scale_r);
      default:         cfg_prdata = '0;
    endcase
  end

  assign cfg.bank_shift  = bank_shift_r;
  assign cfg.bank_mask   = bank_mask_r;
  assign cfg.region_mask = region_mask_r;
  assign cfg.step_scale  = step_scale_r;

  psp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg        (cfg),
    .st_req     (st_req),
    .st_rdata   (st_rdata),
    .rom_req    (rom_req),
    .rom_rdata  (rom_rdata),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .mul_p      (mul_p)
  );

  psp_reg_store u_reg_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (st_req),
    .rdata (st_rdata)
  );

  psp_sample_mem u_sample_mem (
    .clk     (clk),
    .req     (rom_req),
    .rdata_r (rom_rdata)
  );

  psp_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (mul_p)
  );

endmodule

/* rtl/core/psp_reg_store.sv */
// 256-byte register store with per-entry valid bits; unwritten bytes read as 0xff.
module psp_reg_store
  import psp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  store_req_t req,
  output logic [7:0] rdata
);

  logic [7:0] store_mem [256];
  logic [255:0] vld_r;
  logic [7:0] mem_q_r;
  logic       vld_q_r;

  // Storage array, no reset
  always_ff @(posedge clk) begin
    if (req.we) begin
      store_mem[req.waddr] <= req.wdata;
    end
    mem_q_r <= store_mem[req.raddr];
  end

  // Valid bits stand in for the all-ones reset value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
      vld_q_r <= vld_r[req.raddr];
    end
  end

  assign rdata = vld_q_r ? mem_q_r : STORE_RESET;

endmodule

/* rtl/core/psp_sample_mem.sv */
// Sample byte memory, one address per cycle, registered read.
module psp_sample_mem
  import psp_pkg::*;
(
  input  logic       clk,
  input  rom_req_t   req,
  output logic [7:0] rdata_r
);

  logic [7:0] rom_mem [ROM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      rom_mem[req.addr] <= req.wdata;
    end
    rdata_r <= rom_mem[req.addr];
  end

endmodule

/* rtl/core/psp_mul.sv */
// Shared signed-by-unsigned multiplier with registered product.
module psp_mul
  import psp_pkg::*;
(
  input  logic                      clk,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic        [MUL_B_W-1:0] b,
  output logic signed [MUL_P_W-1:0] prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= a * $signed({1'b0, b});
  end

endmodule

/* rtl/core/psp_ctrl.sv */
// Host command decode and per-channel render sequencer with output register.
module psp_ctrl
  import psp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [1:0]                in_tuser,
  input  logic [47:0]               in_tdata,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [47:0]               out_tdata,
  input  cfg_t                      cfg,
  output store_req_t                st_req,
  input  logic [7:0]                st_rdata,
  output rom_req_t                  rom_req,
  input  logic [7:0]                rom_rdata,
  output logic signed [MUL_A_W-1:0] mul_a,
  output logic        [MUL_B_W-1:0] mul_b,
  input  logic signed [MUL_P_W-1:0] mul_p
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_HWR   = 17'h00002,
    S_HRD   = 17'h00004,
    S_HRDW  = 17'h00008,
    S_LOAD  = 17'h00010,
    S_RD    = 17'h00020,
    S_EVAL  = 17'h00040,
    S_FETCH = 17'h00080,
    S_MUL_L = 17'h00100,
    S_MUL_R = 17'h00200,
    S_MUL_P = 17'h00400,
    S_ADV   = 17'h00800,
    S_WB_AM = 17'h01000,
    S_WB_AH = 17'h02000,
    S_WB_FL = 17'h04000,
    S_NEXT  = 17'h08000,
    S_DONE  = 17'h10000
  } state_t;

  // Slots of the per-channel register snapshot, in read order
  localparam logic [3:0] CAP_FLAGS  = 4'd0;
  localparam logic [3:0] CAP_CUR_H  = 4'd1;
  localparam logic [3:0] CAP_CUR_M  = 4'd2;
  localparam logic [3:0] CAP_LOOP_H = 4'd3;
  localparam logic [3:0] CAP_LOOP_M = 4'd4;
  localparam logic [3:0] CAP_END    = 4'd5;
  localparam logic [3:0] CAP_LVOL   = 4'd6;
  localparam logic [3:0] CAP_RVOL   = 4'd7;
  localparam logic [3:0] CAP_PITCH  = 4'd8;
  localparam logic [3:0] CAP_N      = 4'd9;

  localparam logic [CH_BITS-1:0] CH_LAST = CH_BITS'(CHANNELS - 1);

  function automatic logic [7:0] rd_ofs(input logic [3:0] idx);
    logic [7:0] ofs;
    case (idx)
      CAP_FLAGS:  ofs = OFS_FLAGS;
      CAP_CUR_H:  ofs = OFS_CUR_H;
      CAP_CUR_M:  ofs = OFS_CUR_M;
      CAP_LOOP_H: ofs = OFS_LOOP_H;
      CAP_LOOP_M: ofs = OFS_LOOP_M;
      CAP_END:    ofs = OFS_END;
      CAP_LVOL:   ofs = OFS_LVOL;
      CAP_RVOL:   ofs = OFS_RVOL;
      CAP_PITCH:  ofs = OFS_PITCH;
      default:    ofs = OFS_FLAGS;
    endcase
    return ofs;
  endfunction

  state_t state_r, state_nxt;
  logic [7:0]               hreg_addr_r, hreg_addr_nxt;
  logic [7:0]               hreg_data_r, hreg_data_nxt;
  logic [ROM_ADDR_BITS-1:0] hrom_addr_r, hrom_addr_nxt;
  logic [7:0]               hrom_data_r, hrom_data_nxt;
  logic [CH_BITS-1:0]       ch_r, ch_nxt;
  logic [3:0]               rstep_r, rstep_nxt;
  logic [23:0]              addr_r, addr_nxt;
  logic [7:0]               flags_r, flags_nxt;
  logic [ROM_ADDR_BITS-1:0] rom_idx_r, rom_idx_nxt;
  logic signed [8:0]        v_r, v_nxt;
  logic [19:0]              acc_l_r, acc_l_nxt;
  logic [19:0]              acc_r_r, acc_r_nxt;
  logic [7:0]               res_rd_r, res_rd_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [47:0]              out_data_r, out_data_nxt;

  logic [7:0] cap_r [9];
  logic [7:0] frac_r [CHANNELS];
  logic       cap_we;
  logic [3:0] cap_idx;
  logic       frac_we;
  logic [7:0] frac_wdata;

  logic [7:0]               chan_base;
  logic [23:0]              cur_addr;
  logic [23:0]              loop_addr;
  logic [7:0]               end_p1;
  logic                     hit;
  logic [23:0]              sel_addr;
  logic [7:0]               sel_flags;
  logic [ROM_ADDR_BITS-1:0] bank_base;
  logic [ROM_ADDR_BITS-1:0] region_off;
  logic signed [8:0]        v_now;
  logic                     accept;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Channel c owns bytes 8c..8c+7 and 0x80+8c..0x80+8c+7
  assign chan_base = {1'b0, ch_r, 3'b000};

  // End-of-sample check and sample index; only a non-looping voice goes inactive
  assign cur_addr  = {cap_r[CAP_CUR_H], cap_r[CAP_CUR_M], frac_r[ch_r]};
  assign loop_addr = {cap_r[CAP_LOOP_H], cap_r[CAP_LOOP_M], 8'h00};
  assign end_p1    = cap_r[CAP_END] + 8'd1;
  assign hit       = (cur_addr[23:16] == end_p1);
  assign sel_addr  = (hit && !cap_r[CAP_FLAGS][1]) ? loop_addr : cur_addr;
  assign sel_flags = (hit && cap_r[CAP_FLAGS][1]) ? (cap_r[CAP_FLAGS] | 8'h01)
                                                  : cap_r[CAP_FLAGS];
  assign bank_base = ROM_ADDR_BITS'(cap_r[CAP_FLAGS] & cfg.bank_mask) << cfg.bank_shift;
  assign region_off = ROM_ADDR_BITS'(sel_addr[23:8] & cfg.region_mask);

  // Centered sample
  assign v_now = $signed({1'b0, rom_rdata} - {1'b0, SAMPLE_BIAS});

  always_comb begin
    state_nxt     = state_r;
    hreg_addr_nxt = hreg_addr_r;
    hreg_data_nxt = hreg_data_r;
    hrom_addr_nxt = hrom_addr_r;
    hrom_data_nxt = hrom_data_r;
    ch_nxt        = ch_r;
    rstep_nxt     = rstep_r;
    addr_nxt      = addr_r;
    flags_nxt     = flags_r;
    rom_idx_nxt   = rom_idx_r;
    v_nxt         = v_r;
    acc_l_nxt     = acc_l_r;
    acc_r_nxt     = acc_r_r;
    res_rd_nxt    = res_rd_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    st_req        = '0;
    rom_req       = '0;
    rom_req.addr  = rom_idx_r;
    mul_a         = '0;
    mul_b         = '0;
    cap_we        = 1'b0;
    cap_idx       = rstep_r - 4'd1;
    frac_we       = 1'b0;
    frac_wdata    = flags_r[0] ? 8'h00 : addr_r[7:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          hreg_addr_nxt = in_tdata[7:0];
          hreg_data_nxt = in_tdata[15:8];
          hrom_addr_nxt = in_tdata[34:16];
          hrom_data_nxt = in_tdata[42:35];
          acc_l_nxt     = '0;
          acc_r_nxt     = '0;
          res_rd_nxt    = '0;
          ch_nxt        = '0;
          rstep_nxt     = '0;
          case (func_t'(in_tuser))
            FUNC_WR_REG: state_nxt = S_HWR;
            FUNC_RD_REG: state_nxt = S_HRD;
            FUNC_LOAD:   state_nxt = S_LOAD;
            FUNC_RENDER: state_nxt = S_RD;
            default:     state_nxt = S_IDLE;
          endcase
        end
      end
      // Host register write
      S_HWR: begin
        st_req.we    = 1'b1;
        st_req.waddr = hreg_addr_r;
        st_req.wdata = hreg_data_r;
        state_nxt    = S_DONE;
      end
      // Host register read
      S_HRD: begin
        st_req.raddr = hreg_addr_r;
        state_nxt    = S_HRDW;
      end
      S_HRDW: begin
        res_rd_nxt = st_rdata;
        state_nxt  = S_DONE;
      end
      // Host sample load
      S_LOAD: begin
        rom_req.we    = 1'b1;
        rom_req.addr  = hrom_addr_r;
        rom_req.wdata = hrom_data_r;
        state_nxt     = S_DONE;
      end
      // Snapshot the channel's bytes, one read per beat; the store registers each read
      S_RD: begin
        st_req.raddr = chan_base | rd_ofs(rstep_r);
        cap_we       = (rstep_r != 4'd0);
        rstep_nxt    = rstep_r + 4'd1;
        if (rstep_r == CAP_N) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        flags_nxt   = sel_flags;
        addr_nxt    = sel_addr;
        rom_idx_nxt = bank_base + region_off;
        if (cap_r[CAP_FLAGS][0]) begin
          state_nxt = S_NEXT;
        end else if (hit && cap_r[CAP_FLAGS][1]) begin
          state_nxt = S_WB_AM;
        end else begin
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        state_nxt = S_MUL_L;
      end
      S_MUL_L: begin
        v_nxt     = v_now;
        mul_a     = MUL_A_W'(v_now);
        mul_b     = MUL_B_W'(cap_r[CAP_LVOL]);
        state_nxt = S_MUL_R;
      end
      S_MUL_R: begin
        mul_a     = MUL_A_W'(v_r);
        mul_b     = MUL_B_W'(cap_r[CAP_RVOL]);
        acc_l_nxt = acc_l_r + mul_p[19:0];
        state_nxt = S_MUL_P;
      end
      S_MUL_P: begin
        mul_a     = $signed(MUL_A_W'(cap_r[CAP_PITCH]));
        mul_b     = cfg.step_scale;
        acc_r_nxt = acc_r_r + mul_p[19:0];
        state_nxt = S_ADV;
      end
      // Step = pitch * rate factor, Q16 truncated
      S_ADV: begin
        addr_nxt  = addr_r + 24'(mul_p[MUL_P_W-1:16]);
        state_nxt = S_WB_AM;
      end
      S_WB_AM: begin
        st_req.we    = 1'b1;
        st_req.waddr = chan_base | OFS_CUR_M;
        st_req.wdata = addr_r[15:8];
        state_nxt    = S_WB_AH;
      end
      S_WB_AH: begin
        st_req.we    = 1'b1;
        st_req.waddr = chan_base | OFS_CUR_H;
        st_req.wdata = addr_r[23:16];
        state_nxt    = S_WB_FL;
      end
      S_WB_FL: begin
        st_req.we    = 1'b1;
        st_req.waddr = chan_base | OFS_FLAGS;
        st_req.wdata = flags_r;
        frac_we      = 1'b1;
        state_nxt    = S_NEXT;
      end
      S_NEXT: begin
        rstep_nxt = '0;
        if (ch_r == CH_LAST) begin
          state_nxt = S_DONE;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      // Hand the result to the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {acc_r_r, acc_l_r, res_rd_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= '0;
      rstep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      rstep_r     <= rstep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    hreg_addr_r <= hreg_addr_nxt;
    hreg_data_r <= hreg_data_nxt;
    hrom_addr_r <= hrom_addr_nxt;
    hrom_data_r <= hrom_data_nxt;
    addr_r      <= addr_nxt;
    flags_r     <= flags_nxt;
    rom_idx_r   <= rom_idx_nxt;
    v_r         <= v_nxt;
    acc_l_r     <= acc_l_nxt;
    acc_r_r     <= acc_r_nxt;
    res_rd_r    <= res_rd_nxt;
    out_data_r  <= out_data_nxt;
    if (cap_we) begin
      cap_r[cap_idx] <= st_rdata;
    end
  end

  // Address fractions reset to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        frac_r[i] <= '0;
      end
    end else if (frac_we) begin
      frac_r[ch_r] <= frac_wdata;
    end
  end

endmodule

/* tb/tb_pcm_sample_player_16ch.sv */
// Self-checking testbench for the sixteen-channel sample player: stream stimulus, APB setup, mirror model.
`timescale 1ns / 1ps

module tb_pcm_sample_player_16ch;
  import psp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned PHASE_BEATS = 75;

  // One result beat as the block should deliver it
  typedef struct packed {
    logic [7:0]  read_data;
    logic [19:0] left_out;
    logic [19:0] right_out;
  } frame_result_t;

  // Mirror of the player state; predicts and checks result beats
  class player_mirror;
    logic [7:0]  store[256];
    logic [7:0]  frac[16];
    logic [7:0]  rom_img[ROM_DEPTH];
    bit          rom_set[ROM_DEPTH];
    int unsigned bank_shift, bank_mask, region_mask, step_scale;
    frame_result_t due[$];
    int unsigned fails;

    function new();
      foreach (store[i]) store[i] = STORE_RESET;
      foreach (frac[i]) frac[i] = 8'h00;
      bank_shift  = 12;
      bank_mask   = 112;
      region_mask = 65535;
      step_scale  = 47554;
      fails       = 0;
    endfunction

    function void set_config(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_BANK_SHIFT:  bank_shift  = val[4:0];
        REG_BANK_MASK:   bank_mask   = val[7:0];
        REG_REGION_MASK: region_mask = val[15:0];
        REG_STEP_SCALE:  step_scale  = val[17:0];
        default: ;
      endcase
    endfunction

    // Mix one stereo frame; without commit it only collects fetches of unloaded bytes
    function void mix_frame(input bit commit, ref int unsigned holes[$],
                            output logic [19:0] l_sum, output logic [19:0] r_sum);
      logic [7:0]      st[256];
      logic [7:0]      fr[16];
      logic [7:0]      flags;
      logic [7:0]      end_hi;
      logic [23:0]     addr;
      logic [23:0]     loop_addr;
      longint unsigned base, inc;
      int unsigned     idx;
      int              acc_l, acc_r, smp, b;
      bit              play;
      st = store;
      fr = frac;
      acc_l = 0;
      acc_r = 0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        b = 8 * ch;
        flags = st[b + OFS_FLAGS];
        if (flags[0]) continue;
        addr      = {st[b + OFS_CUR_H], st[b + OFS_CUR_M], fr[ch]};
        loop_addr = {st[b + OFS_LOOP_H], st[b + OFS_LOOP_M], 8'h00};
        end_hi    = st[b + OFS_END] + 8'd1;
        play = 1'b1;
        // end of sample: reload loop or stop the voice
        if (addr[23:16] == end_hi) begin
          if (!flags[1]) begin
            addr = loop_addr;
          end else begin
            flags[0] = 1'b1;
            st[b + OFS_FLAGS] = flags;
            play = 1'b0;
          end
        end
        if (play) begin
          base = longint'(flags & bank_mask[7:0]) << bank_shift;
          idx  = int'(19'(base + (addr[23:8] & region_mask[15:0])));
          if (!rom_set[idx]) holes.push_back(idx);
          smp   = int'(rom_img[idx]) - 128;
          acc_l += smp * int'(st[b + OFS_LVOL]);
          acc_r += smp * int'(st[b + OFS_RVOL]);
          inc  = (longint'(st[b + OFS_PITCH]) * step_scale) >> 16;
          addr = addr + 24'(inc);
        end
        st[b + OFS_CUR_M] = addr[15:8];
        st[b + OFS_CUR_H] = addr[23:16];
        fr[ch] = flags[0] ? 8'h00 : addr[7:0];
      end
      l_sum = acc_l[19:0];
      r_sum = acc_r[19:0];
      if (commit) begin
        store = st;
        frac  = fr;
      end
    endfunction

    function void unloaded_fetches(ref int unsigned holes[$]);
      logic [19:0] l, r;
      mix_frame(1'b0, holes, l, r);
    endfunction

    // Accepted command beat: update the mirror and queue the expected result
    function void accept_cmd(func_t f, logic [7:0] ra, logic [7:0] rd,
                             logic [18:0] ma, logic [7:0] md);
      int unsigned   ignored[$];
      logic [19:0]   l, r;
      frame_result_t e;
      e = '0;
      case (f)
        FUNC_WR_REG: store[ra] = rd;
        FUNC_RD_REG: e.read_data = store[ra];
        FUNC_LOAD: begin
          rom_img[ma] = md;
          rom_set[ma] = 1'b1;
        end
        FUNC_RENDER: begin
          mix_frame(1'b1, ignored, l, r);
          e.left_out  = l;
          e.right_out = r;
        end
        default: ;
      endcase
      due.push_back(e);
    endfunction

    function void compare_beat(logic [47:0] beat);
      frame_result_t e;
      if (due.size() == 0) begin
        $error("result beat with nothing expected: %h", beat);
        fails++;
        return;
      end
      e = due.pop_front();
      if (beat[7:0] !== e.read_data) begin
        $error("read_data: expected %0d, got %0d", e.read_data, beat[7:0]);
        fails++;
      end
      if (beat[27:8] !== e.left_out) begin
        $error("left_out: expected %0d, got %0d", $signed(e.left_out), $signed(beat[27:8]));
        fails++;
      end
      if (beat[47:28] !== e.right_out) begin
        $error("right_out: expected %0d, got %0d", $signed(e.right_out),
               $signed(beat[47:28]));
        fails++;
      end
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction

    function void close_out();
      if (due.size() != 0) begin
        $error("%0d result beats never arrived", due.size());
        fails++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [47:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  player_mirror board = new();
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct = 0;
  int unsigned  beats_sent = 0;
  int unsigned  cycles = 0;

  pcm_sample_player_16ch i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("pcm_sample_player_16ch regression: fail");
      $finish;
    end
  end

  // Result side: random back-pressure, check every accepted beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.compare_beat(out_tdata);
    out_tready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  task automatic send_cmd(func_t f, logic [7:0] ra, logic [7:0] rd,
                          logic [18:0] ma, logic [7:0] md);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {5'b0, md, ma, rd, ra};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.accept_cmd(f, ra, rd, ma, md);
    beats_sent++;
  endtask

  // Unused fields carry noise; the block must ignore them
  task automatic wr_reg(logic [7:0] a, logic [7:0] d);
    send_cmd(FUNC_WR_REG, a, d, 19'($urandom), 8'($urandom));
  endtask

  task automatic rd_reg(logic [7:0] a);
    send_cmd(FUNC_RD_REG, a, 8'($urandom), 19'($urandom), 8'($urandom));
  endtask

  task automatic load_byte(logic [18:0] a, logic [7:0] d);
    send_cmd(FUNC_LOAD, 8'($urandom), 8'($urandom), a, d);
  endtask

  // Load every byte the next frame will fetch that was never written, then render
  task automatic render_frame();
    int unsigned holes[$];
    board.unloaded_fetches(holes);
    foreach (holes[i]) load_byte(19'(holes[i]), 8'($urandom));
    send_cmd(FUNC_RENDER, 8'($urandom), 8'($urandom), 19'($urandom), 8'($urandom));
  endtask

  // Full voice setup, usually placed just below its end address so it soon wraps or stops
  task automatic arm_voice(int ch, bit loop_off);
    logic [7:0] b, h;
    b = 8'(8 * ch);
    h = 8'($urandom);
    wr_reg(b + OFS_LVOL, 8'($urandom));
    wr_reg(b + OFS_RVOL, 8'($urandom));
    wr_reg(b + OFS_LOOP_M, 8'($urandom));
    wr_reg(b + OFS_LOOP_H, 8'($urandom));
    wr_reg(b + OFS_PITCH, 8'($urandom));
    wr_reg(b + OFS_END, ($urandom_range(3) == 0) ? 8'($urandom) : h);
    wr_reg(b + OFS_CUR_M, 8'($urandom_range(255, 192)));
    wr_reg(b + OFS_CUR_H, h);
    wr_reg(b + OFS_FLAGS, {6'($urandom), loop_off, 1'b0});
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain(int unsigned settle);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_cfg(reg_idx_t idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    board.set_config(idx, val);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_traffic(int unsigned quota);
    int unsigned first, pick;
    bit          paused;
    first  = beats_sent;
    paused = 1'b0;
    while (beats_sent - first < quota) begin
      // mid-phase hold-off until the block has answered everything
      if (!paused && (beats_sent - first > quota / 2)) begin
        drain(0);
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 40) render_frame();
      else if (pick < 55) arm_voice($urandom_range(CHANNELS - 1), 1'($urandom));
      else if (pick < 70) wr_reg(8'($urandom), 8'($urandom));
      else if (pick < 80) rd_reg(8'($urandom));
      else if (pick < 90) load_byte(19'($urandom), 8'($urandom));
      else if (pick < 95) wr_reg(8'(8 * $urandom_range(CHANNELS - 1)) + OFS_PITCH,
                                 8'($urandom));
      else wr_reg(8'(8 * $urandom_range(CHANNELS - 1)) + OFS_FLAGS, 8'($urandom));
    end
  endtask

  initial begin
    logic [31:0] shift_v, mask_v, region_v, scale_v;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: store extremes, memory extremes, silent frame
    rd_reg(8'h00);
    rd_reg(8'hff);
    send_cmd(FUNC_WR_REG, 8'h00, 8'h00, 19'h7ffff, 8'hff);
    send_cmd(FUNC_WR_REG, 8'hff, 8'hff, 19'h00000, 8'h00);
    rd_reg(8'h00);
    send_cmd(FUNC_LOAD, 8'hff, 8'hff, 19'h00000, 8'h00);
    send_cmd(FUNC_LOAD, 8'h00, 8'h00, 19'h7ffff, 8'hff);
    render_frame();
    // channel 0 sits on its end with looping on: reload, then play from the loop
    wr_reg(OFS_END, 8'h10);
    wr_reg(OFS_CUR_H, 8'h11);
    wr_reg(OFS_FLAGS, 8'hf0);
    render_frame();
    render_frame();
    // channel 15 at its end (end byte wraps to zero) with looping off: goes silent
    wr_reg(8'(8 * 15) + OFS_CUR_H, 8'h00);
    wr_reg(8'(8 * 15) + OFS_FLAGS, 8'h02);
    render_frame();
    rd_reg(8'(8 * 15) + OFS_FLAGS);
    drain(16);

    // Random phases, each with its setup and one of four idle patterns
    for (int k = 1; k <= 6; k++) begin
      case (k % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 79; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 79; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      case (k)
        1: begin shift_v = 0;  mask_v = 0;   region_v = 0;      scale_v = 0;      end
        2: begin shift_v = 24; mask_v = 255; region_v = 65535;  scale_v = 262143; end
        5: begin shift_v = 16; mask_v = 112; region_v = 255;    scale_v = 65536;  end
        default: begin
          shift_v  = $urandom_range(24);
          mask_v   = $urandom_range(255);
          region_v = $urandom_range(65535);
          scale_v  = $urandom_range(262143);
        end
      endcase
      write_cfg(REG_BANK_SHIFT, shift_v);
      write_cfg(REG_BANK_MASK, mask_v);
      write_cfg(REG_REGION_MASK, region_v);
      write_cfg(REG_STEP_SCALE, scale_v);
      random_traffic(PHASE_BEATS);
      drain(16);
    end

    drain(400);
    board.close_out();
    if (board.fails == 0) begin
      $display("pcm_sample_player_16ch regression: pass");
    end else begin
      $display("pcm_sample_player_16ch regression: fail");
    end
    $finish;
  end

endmodule

/* pcm_sample_player_16ch.f */
rtl/core/psp_pkg.sv
rtl/core/psp_reg_store.sv
rtl/core/psp_sample_mem.sv
rtl/core/psp_mul.sv
rtl/core/psp_ctrl.sv
rtl/core/pcm_sample_player_16ch.sv
tb/tb_pcm_sample_player_16ch.sv
